// ===== hw/rtl/spi_serial_sram_slave_macros.svh =====
// Assertion macros used by the checker file of the serial SRAM slave.
`ifndef SPI_SERIAL_SRAM_SLAVE_MACROS_SVH
`define SPI_SERIAL_SRAM_SLAVE_MACROS_SVH

// Property checked on every rising clock edge, switched off while reset is low.
`define SSS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define SSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/sss_pkg.sv =====
// Shared types and constants of the serial SRAM slave.
package sss_pkg;

    // Memory size and write page; both must be powers of two.
    localparam int MEM_BYTES  = 65536;
    localparam int PAGE_BYTES = 256;
    localparam int MEM_AW     = $clog2(MEM_BYTES);
    localparam int PAGE_AW    = $clog2(PAGE_BYTES);

    localparam int                ADDR_W    = 24;
    localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'(MEM_BYTES - 1);

    localparam logic [7:0] CMD_RD        = 8'h03;
    localparam logic [7:0] CMD_RD_FAST   = 8'h0b;
    localparam logic [7:0] CMD_WRITE     = 8'h02;
    localparam logic [7:0] CMD_RDID      = 8'h9f;
    localparam logic [7:0] CMD_RST_EN    = 8'h66;
    localparam logic [7:0] CMD_RST       = 8'h99;
    localparam logic [7:0] IDLE_BYTE     = 8'hff;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ADDR    = 3'd1,
        PH_DUMMY   = 3'd2,
        PH_READ    = 3'd3,
        PH_WRITE   = 3'd4,
        PH_IDDUMMY = 3'd5,
        PH_IDDATA  = 3'd6,
        PH_IGNORE  = 3'd7
    } t_phase;

    typedef enum logic {
        CS_WAIT = 1'b0,
        CS_EXEC = 1'b1
    } t_ctrl_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;  // latch the incoming transfer and read the memory
        logic commit;   // update protocol state, write memory, load result
    } t_dp_cmd;

endpackage

// ===== hw/rtl/sss_ctrl.sv =====
// Handshake controller of the serial SRAM slave.
module sss_ctrl
    import sss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    s_axis_tvalid,
    output logic    s_axis_tready,
    output logic    m_axis_tvalid,
    input  logic    m_axis_tready,
    output t_dp_cmd o_cmd
);

    t_ctrl_state r_state, n_state;
    logic        r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= CS_WAIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        o_cmd         = '0;
        n_out_valid   = r_out_valid && !m_axis_tready;
        unique case (r_state)
            CS_WAIT: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = CS_EXEC;
                end
            end
            CS_EXEC: begin
                // Hold until the result register is free.
                if (!r_out_valid || m_axis_tready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = CS_WAIT;
                end
            end
            default: n_state = CS_WAIT;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;

endmodule

// ===== hw/rtl/sss_datapath.sv =====
// Protocol state, memory and result register of the serial SRAM slave.
module sss_datapath
    import sss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic        i_select,
    input  logic [7:0]  i_mosi_byte,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output logic [7:0]  o_miso_byte,
    output logic        o_data_phase,
    output logic        o_bad_command
);

    logic [7:0]  r_mem [MEM_BYTES];

    logic [31:0]       r_device_id;
    t_phase            r_phase, n_phase;
    logic [7:0]        r_cmd, n_cmd;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [2:0]        r_count, n_count;
    logic              r_armed, n_armed;

    logic              r_select;
    logic [7:0]        r_byte;
    logic [7:0]        r_rd_data;
    logic [7:0]        r_miso, n_miso;
    logic              r_data, n_data;
    logic              r_bad, n_bad;
    logic              w_mem_we;
    logic [PAGE_AW-1:0] w_page_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id <= '0;
        end else if (i_cfg_we) begin
            r_device_id <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cmd   <= '0;
            r_addr  <= '0;
            r_count <= '0;
            r_armed <= 1'b0;
        end else if (i_cmd.commit) begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_addr  <= n_addr;
            r_count <= n_count;
            r_armed <= n_armed;
        end
    end

    // Input latch and registered memory read at the current address.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_select  <= i_select;
            r_byte    <= i_mosi_byte;
            r_rd_data <= r_mem[r_addr[MEM_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_addr[MEM_AW-1:0]] <= r_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_miso <= n_miso;
            r_data <= n_data;
            r_bad  <= n_bad;
        end
    end

    assign w_page_off = r_addr[PAGE_AW-1:0] + 1'b1;

    always_comb begin
        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_addr   = r_addr;
        n_count  = r_count;
        n_armed  = r_armed;
        n_miso   = IDLE_BYTE;
        n_data   = 1'b0;
        n_bad    = 1'b0;
        w_mem_we = 1'b0;
        if (!r_select) begin
            n_phase = PH_IDLE;
            n_count = '0;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    n_cmd   = r_byte;
                    n_count = '0;
                    n_armed = (r_byte == CMD_RST_EN);
                    case (r_byte) inside
                        CMD_RD, CMD_RD_FAST, CMD_WRITE: begin
                            n_addr  = '0;
                            n_phase = PH_ADDR;
                        end
                        CMD_RDID:    n_phase = PH_IDDUMMY;
                        CMD_RST_EN:  n_phase = PH_IGNORE;
                        CMD_RST: begin
                            if (r_armed) begin
                                n_cmd  = '0;
                                n_addr = '0;
                            end
                            n_phase = PH_IGNORE;
                        end
                        default: begin
                            n_bad   = 1'b1;
                            n_phase = PH_IGNORE;
                        end
                    endcase
                end
                PH_ADDR: begin
                    n_addr  = {r_addr[ADDR_W-9:0], r_byte};
                    n_count = r_count + 3'd1;
                    if (r_count == 3'd2) begin
                        n_addr  = n_addr & ADDR_MASK;
                        n_count = '0;
                        if (r_cmd == CMD_RD_FAST) begin
                            n_phase = PH_DUMMY;
                        end else if (r_cmd == CMD_WRITE) begin
                            n_phase = PH_WRITE;
                        end else begin
                            n_phase = PH_READ;
                        end
                    end
                end
                PH_DUMMY: n_phase = PH_READ;
                PH_READ: begin
                    n_miso = r_rd_data;
                    n_data = 1'b1;
                    n_addr = (r_addr + 1'b1) & ADDR_MASK;
                end
                PH_WRITE: begin
                    // Write once, on the commit of this transfer.
                    w_mem_we = i_cmd.commit;
                    n_data   = 1'b1;
                    n_addr   = {r_addr[ADDR_W-1:PAGE_AW], w_page_off} & ADDR_MASK;
                end
                PH_IDDUMMY: begin
                    n_count = r_count + 3'd1;
                    if (r_count == 3'd2) begin
                        n_count = '0;
                        n_phase = PH_IDDATA;
                    end
                end
                PH_IDDATA: begin
                    // Send the identification word most significant byte first.
                    case (r_count[1:0])
                        2'd0:    n_miso = r_device_id[31:24];
                        2'd1:    n_miso = r_device_id[23:16];
                        2'd2:    n_miso = r_device_id[15:8];
                        default: n_miso = r_device_id[7:0];
                    endcase
                    n_count = r_count + 3'd1;
                    if (r_count == 3'd3) begin
                        n_count = '0;
                        n_phase = PH_IGNORE;
                    end
                end
                PH_IGNORE: n_phase = PH_IGNORE;
                default:   n_phase = PH_IDLE;
            endcase
        end
    end

    assign o_miso_byte   = r_miso;
    assign o_data_phase  = r_data;
    assign o_bad_command = r_bad;

endmodule

// ===== hw/rtl/spi_serial_sram_slave.sv =====
// Top level of the serial SRAM slave: controller plus datapath.
//
// Behaves as a byte-wide SPI serial SRAM seen from its bus. Each input
// transfer is one byte exchanged with chip select low (s_axis_tuser high)
// or a deselect event (s_axis_tuser low), which ends the transaction.
// Each input transfer yields exactly one output transfer: the byte shifted
// back to the host on m_axis_tdata, and the data-phase and bad-command
// flags on m_axis_tuser.
// The user loads the device identification word through i_cfg_we and
// i_cfg_wdata only while the block is idle; the block has no check on it.
// A transfer is latched with its memory read when accepted; its result is
// loaded into the output register once that register is free.
// A new transfer is taken only once the last one has been executed, since
// the memory read is registered before the result is formed.
// The input side takes the next transfer while a result still waits on
// the output register; if the receiver stalls, the next result holds the
// block and s_axis_tready stays low until the output register frees.
// Reset (i_rst_n low, synchronous) clears the protocol state, the
// identification word and the output valid; the memory is not cleared.
// The memory is a power-of-two array of MEM_BYTES bytes; write addresses
// wrap within a PAGE_BYTES page.
module spi_serial_sram_slave
    import sss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] mosi_byte
    input  logic        s_axis_tuser,   // [0] select
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] miso_byte
    output logic [1:0]  m_axis_tuser,   // [0] data_phase, [1] bad_command
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    t_dp_cmd w_cmd;

    // Sequence accept, execute and result hand-off.
    sss_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_cmd         (w_cmd)
    );

    // Protocol phase machine, memory and result register.
    sss_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_select      (s_axis_tuser),
        .i_mosi_byte   (s_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_miso_byte   (m_axis_tdata),
        .o_data_phase  (m_axis_tuser[0]),
        .o_bad_command (m_axis_tuser[1])
    );

endmodule

// ===== hw/rtl/sss_checker.sv =====
// Port-level assertions of the serial SRAM slave, bound to the top level.
`include "spi_serial_sram_slave_macros.svh"

module sss_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser
);

    `SSS_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")
    `SSS_ASSERT(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
    `SSS_ASSERT(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "transfer taken while one is in work")
    `SSS_ASSERT(a_bad_idle_byte, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 8'hff && !m_axis_tuser[0], "flagged command with data")
    `SSS_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind spi_serial_sram_slave sss_checker u_sss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== bench/spi_serial_sram_slave_test.sv =====
// Self-checking bench for the serial SRAM slave: directed table, then random SPI transactions.
`timescale 1ns / 100ps

module spi_serial_sram_slave_test;
    import sss_pkg::*;

    // One reply byte as seen on the master side.
    typedef struct packed {
        logic [7:0] miso;
        logic       data_phase;
        logic       bad_command;
    } t_sram_reply;

    // One row of the directed table; rep is only used when typed is set.
    typedef struct packed {
        logic        sel;
        logic [7:0]  mosi;
        logic        typed;
        t_sram_reply rep;
    } t_stim_row;

    localparam t_sram_reply IDLE_REPLY = '{IDLE_BYTE, 1'b0, 1'b0};
    localparam t_sram_reply DATA_REPLY = '{IDLE_BYTE, 1'b1, 1'b0};
    localparam t_sram_reply BAD_REPLY  = '{IDLE_BYTE, 1'b0, 1'b1};
    localparam t_sram_reply ID0_REPLY  = '{8'h00, 1'b0, 1'b0};
    localparam t_sram_reply NO_REPLY   = '0;

    localparam int NROWS        = 39;
    localparam int RANDOM_ITEMS = 1300;
    localparam int NPHASES      = 4;

    // Directed part. Runs straight after reset, so device_id is still zero.
    localparam t_stim_row DIRECTED_ROWS [NROWS] = '{
        '{1'b0, 8'h00,          1'b1, IDLE_REPLY},   // deselect straight after reset
        '{1'b1, CMD_RDID,       1'b1, IDLE_REPLY},
        '{1'b1, 8'h00,          1'b0, NO_REPLY},
        '{1'b1, 8'hff,          1'b0, NO_REPLY},
        '{1'b1, 8'h00,          1'b0, NO_REPLY},
        '{1'b1, 8'hff,          1'b1, ID0_REPLY},    // four ID bytes of a cleared word
        '{1'b1, 8'h00,          1'b1, ID0_REPLY},
        '{1'b1, 8'hff,          1'b1, ID0_REPLY},
        '{1'b1, 8'h00,          1'b1, ID0_REPLY},
        '{1'b1, 8'h55,          1'b1, IDLE_REPLY},   // trailing byte after ID is ignored
        '{1'b0, 8'hff,          1'b1, IDLE_REPLY},
        '{1'b1, CMD_WRITE,      1'b0, NO_REPLY},
        '{1'b1, 8'hff,          1'b0, NO_REPLY},     // top address byte masked away
        '{1'b1, 8'hff,          1'b0, NO_REPLY},
        '{1'b1, 8'hff,          1'b0, NO_REPLY},
        '{1'b1, 8'h5a,          1'b1, DATA_REPLY},   // last byte of memory
        '{1'b1, 8'ha5,          1'b1, DATA_REPLY},   // wraps to the start of the page
        '{1'b0, 8'h00,          1'b0, NO_REPLY},
        '{1'b1, CMD_RD_FAST,    1'b0, NO_REPLY},
        '{1'b1, 8'h00,          1'b0, NO_REPLY},
        '{1'b1, 8'hff,          1'b0, NO_REPLY},
        '{1'b1, 8'hff,          1'b0, NO_REPLY},
        '{1'b1, 8'h3c,          1'b0, NO_REPLY},     // dummy byte
        '{1'b1, 8'h00,          1'b0, NO_REPLY},
        '{1'b0, 8'h00,          1'b0, NO_REPLY},
        '{1'b1, CMD_RD,         1'b0, NO_REPLY},
        '{1'b1, 8'h12,          1'b0, NO_REPLY},
        '{1'b1, 8'hff,          1'b0, NO_REPLY},
        '{1'b1, 8'h00,          1'b0, NO_REPLY},
        '{1'b1, 8'hff,          1'b0, NO_REPLY},     // reads back the wrapped write
        '{1'b0, 8'h00,          1'b0, NO_REPLY},
        '{1'b1, 8'hc3,          1'b1, BAD_REPLY},    // unknown command
        '{1'b0, 8'h00,          1'b0, NO_REPLY},
        '{1'b1, CMD_RST_EN,     1'b0, NO_REPLY},
        '{1'b0, 8'h00,          1'b0, NO_REPLY},
        '{1'b1, CMD_RST,        1'b0, NO_REPLY},     // armed reset
        '{1'b0, 8'h00,          1'b0, NO_REPLY},
        '{1'b1, CMD_RST,        1'b1, IDLE_REPLY},   // reset without enable: silent
        '{1'b0, 8'h00,          1'b0, NO_REPLY}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] mosi_byte
    logic        s_axis_tuser;   // [0] select
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] miso_byte
    logic [1:0]  m_axis_tuser;   // [0] data_phase, [1] bad_command
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;

    // Shadow state of the slave, advanced once per accepted input transfer.
    t_phase      sram_phase;
    logic [7:0]  sram_cmd;
    logic [23:0] sram_addr;
    int          sram_count;
    logic        sram_armed;
    logic [31:0] sram_id_word;
    logic [7:0]  sram_image   [MEM_BYTES];
    bit          sram_written [MEM_BYTES];

    t_sram_reply pending_replies [$];
    logic [15:0] written_starts  [$];

    bit idling_on;
    int rx_stall_left;
    int fail_count;
    int items_sent;
    int replies_checked;
    int data_reads;
    int id_settings;

    spi_serial_sram_slave dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest correct run.
    initial begin
        #(2_000_000);
        $display("TB_ERROR");
        $finish;
    end

    // Advance the shadow state by one transfer and work out the reply it causes.
    task automatic predict_sram_reply(input bit sel, input logic [7:0] mosi,
                                      output t_sram_reply rep);
        logic [PAGE_AW-1:0] page_off;
        rep = IDLE_REPLY;
        if (!sel) begin
            sram_phase = PH_IDLE;
            sram_count = 0;
        end else begin
            case (sram_phase)
                PH_IDLE: begin
                    sram_cmd   = mosi;
                    sram_count = 0;
                    if (mosi == CMD_RD || mosi == CMD_RD_FAST || mosi == CMD_WRITE) begin
                        sram_addr  = '0;
                        sram_phase = PH_ADDR;
                    end else if (mosi == CMD_RDID) begin
                        sram_phase = PH_IDDUMMY;
                    end else if (mosi == CMD_RST_EN) begin
                        sram_phase = PH_IGNORE;
                    end else if (mosi == CMD_RST) begin
                        if (sram_armed) begin
                            sram_cmd  = '0;
                            sram_addr = '0;
                        end
                        sram_phase = PH_IGNORE;
                    end else begin
                        rep.bad_command = 1'b1;
                        sram_phase      = PH_IGNORE;
                    end
                    // any command other than reset-enable drops the arming
                    sram_armed = (mosi == CMD_RST_EN);
                end
                PH_ADDR: begin
                    sram_addr  = {sram_addr[15:0], mosi};
                    sram_count = sram_count + 1;
                    if (sram_count >= 3) begin
                        sram_addr  = sram_addr & ADDR_MASK;
                        sram_count = 0;
                        if (sram_cmd == CMD_RD_FAST)
                            sram_phase = PH_DUMMY;
                        else if (sram_cmd == CMD_WRITE)
                            sram_phase = PH_WRITE;
                        else
                            sram_phase = PH_READ;
                    end
                end
                PH_DUMMY: sram_phase = PH_READ;
                PH_READ: begin
                    rep.miso       = sram_image[sram_addr[MEM_AW-1:0]];
                    rep.data_phase = 1'b1;
                    sram_addr      = (sram_addr + 24'd1) & ADDR_MASK;
                    data_reads     = data_reads + 1;
                end
                PH_WRITE: begin
                    sram_addr = sram_addr & ADDR_MASK;
                    sram_image[sram_addr[MEM_AW-1:0]]   = mosi;
                    sram_written[sram_addr[MEM_AW-1:0]] = 1'b1;
                    // only the offset inside the page advances
                    page_off  = sram_addr[PAGE_AW-1:0] + 1'b1;
                    sram_addr[PAGE_AW-1:0] = page_off;
                    sram_addr = sram_addr & ADDR_MASK;
                    rep.data_phase = 1'b1;
                end
                PH_IDDUMMY: begin
                    sram_count = sram_count + 1;
                    if (sram_count >= 3) begin
                        sram_count = 0;
                        sram_phase = PH_IDDATA;
                    end
                end
                PH_IDDATA: begin
                    rep.miso   = sram_id_word[8*(3-sram_count) +: 8];
                    sram_count = sram_count + 1;
                    if (sram_count >= 4) begin
                        sram_count = 0;
                        sram_phase = PH_IGNORE;
                    end
                end
                default: ;
            endcase
        end
    endtask

    // Present one transfer, hold it until accepted, then log what should come back.
    // A data read of a location never written is turned into a deselect; dropped
    // tells the caller to abandon the rest of that transaction.
    task automatic send_transfer(input bit sel, input logic [7:0] mosi, input bit typed,
                                 input t_sram_reply typed_rep, output bit dropped);
        t_sram_reply rep;
        dropped = 1'b0;
        if (sel && sram_phase == PH_READ && !sram_written[sram_addr[MEM_AW-1:0]]) begin
            sel     = 1'b0;
            dropped = 1'b1;
        end
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= mosi;
        s_axis_tuser  <= sel;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_sram_reply(sel, mosi, rep);
        pending_replies.push_back((typed && !dropped) ? typed_rep : rep);
        items_sent = items_sent + 1;
    endtask

    // Send a run of selected bytes, then deselect unless asked to leave it open.
    task automatic send_plan(input logic [7:0] plan [$], input bit keep_open);
        bit dropped;
        dropped = 1'b0;
        foreach (plan[k]) begin
            if (!dropped)
                send_transfer(1'b1, plan[k], 1'b0, NO_REPLY, dropped);
        end
        if (!keep_open && !dropped)
            send_transfer(1'b0, 8'($urandom_range(0, 255)), 1'b0, NO_REPLY, dropped);
    endtask

    // Addresses biased towards the ends of memory and page edges.
    function automatic logic [23:0] pick_address();
        logic [15:0] low;
        case ($urandom_range(0, 3))
            0:       low = 16'($urandom_range(0, 15));
            1:       low = 16'hfff0 + 16'($urandom_range(0, 15));
            2:       low = {8'($urandom_range(0, 255)), 8'hf8 + 8'($urandom_range(0, 7))};
            default: low = 16'($urandom_range(0, 65535));
        endcase
        return {8'($urandom_range(0, 255)), low};
    endfunction

    // One random transaction: mostly well formed with random content, some noise.
    task automatic random_transaction();
        logic [7:0]  plan [$];
        logic [23:0] a;
        logic [7:0]  c;
        int          r;
        int          len;
        bit          dropped;
        bit          keep_open;
        keep_open = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            a = pick_address();
            plan = {CMD_WRITE, a[23:16], a[15:8], a[7:0]};
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 8);
            repeat (len) plan.push_back(8'($urandom_range(0, 255)));
            written_starts.push_back(a[15:0]);
            if (written_starts.size() > 64)
                void'(written_starts.pop_front());
        end else if (r < 60) begin
            if (written_starts.size() == 0)
                a = pick_address();
            else
                a = {8'($urandom_range(0, 255)),
                     written_starts[$urandom_range(0, written_starts.size() - 1)]
                     + 16'($urandom_range(0, 3))};
            c = $urandom_range(0, 1) ? CMD_RD_FAST : CMD_RD;
            plan = {c, a[23:16], a[15:8], a[7:0]};
            if (c == CMD_RD_FAST)
                plan.push_back(8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 10)) plan.push_back(8'($urandom_range(0, 255)));
        end else if (r < 70) begin
            plan = {CMD_RDID};
            repeat (7 + $urandom_range(0, 2)) plan.push_back(8'($urandom_range(0, 255)));
        end else if (r < 80) begin
            // reset sequence, sometimes without enable or disarmed in between
            if ($urandom_range(0, 4) != 0) begin
                plan = {CMD_RST_EN};
                repeat ($urandom_range(0, 1)) plan.push_back(8'($urandom_range(0, 255)));
                send_plan(plan, 1'b0);
                if ($urandom_range(0, 5) == 0)
                    send_plan({CMD_RDID}, 1'b0);
            end
            plan = {CMD_RST};
            repeat ($urandom_range(0, 1)) plan.push_back(8'($urandom_range(0, 255)));
        end else if (r < 88) begin
            do c = 8'($urandom_range(0, 255));
            while (c == CMD_RD || c == CMD_RD_FAST || c == CMD_WRITE ||
                   c == CMD_RDID || c == CMD_RST_EN || c == CMD_RST);
            plan = {c};
            repeat ($urandom_range(0, 3)) plan.push_back(8'($urandom_range(0, 255)));
        end else begin
            // noise: random select and data, left wherever it ends up
            repeat ($urandom_range(1, 6))
                send_transfer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0,
                              NO_REPLY, dropped);
            return;
        end
        // cut some transactions short to exercise broken sequences
        if (plan.size() > 1 && $urandom_range(0, 9) == 0)
            plan = plan[0:$urandom_range(0, plan.size() - 2)];
        if ($urandom_range(0, 19) == 0)
            keep_open = 1'b1;
        send_plan(plan, keep_open);
    endtask

    // Drain all outstanding replies, let the pipe settle, then load a new ID word.
    task automatic load_device_id(input logic [31:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        sram_id_word  = value;
        id_settings   = id_settings + 1;
    endtask

    // Receiver stalls: random bursts with tready low, started only while idling is on.
    always @(posedge i_clk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left  = rx_stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rx_stall_left  = $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare every output transfer with the oldest outstanding reply.
    always @(posedge i_clk) begin
        t_sram_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected reply: miso %02h tuser %02b", m_axis_tdata,
                             m_axis_tuser);
                fail_count = fail_count + 1;
            end else begin
                want = pending_replies.pop_front();
                replies_checked = replies_checked + 1;
                if (m_axis_tdata !== want.miso || m_axis_tuser[0] !== want.data_phase ||
                    m_axis_tuser[1] !== want.bad_command) begin
                    if (fail_count < 10)
                        $display("reply %0d mismatch: miso %02h/%02h data %b/%b bad %b/%b",
                                 replies_checked, want.miso, m_axis_tdata,
                                 want.data_phase, m_axis_tuser[0],
                                 want.bad_command, m_axis_tuser[1]);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    initial begin
        bit dropped;
        int phase_end;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        m_axis_tready <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        sram_phase    = PH_IDLE;
        sram_cmd      = '0;
        sram_addr     = '0;
        sram_count    = 0;
        sram_armed    = 1'b0;
        sram_id_word  = '0;
        idling_on     = 1'b1;
        rx_stall_left = 0;
        fail_count    = 0;
        items_sent    = 0;
        replies_checked = 0;
        data_reads    = 0;
        id_settings   = 0;

        // hold reset, then release
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed table with the ID word still at its reset value
        for (int k = 0; k < NROWS; k++)
            send_transfer(DIRECTED_ROWS[k].sel, DIRECTED_ROWS[k].mosi,
                          DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].rep, dropped);

        // random traffic in phases, a new ID word for each; drop idling in the last
        for (int p = 0; p < NPHASES; p++) begin
            case (p)
                0:       load_device_id(32'hffff_ffff);
                2:       load_device_id(32'h0000_0000);
                default: load_device_id($urandom);
            endcase
            idling_on = (p != NPHASES - 1);
            phase_end = NROWS + (p + 1) * RANDOM_ITEMS / NPHASES;
            while (items_sent < phase_end)
                random_transaction();
        end

        // drain, then let the pipe settle for stray replies
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d transfers, checked %0d replies including %0d memory reads,",
                 items_sent, replies_checked, data_reads);
        $display("across %0d device_id settings with and without bus stalls.", id_settings);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
